// ===== rtl/mtfzr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfzr_pkg: shared types and constants
// Widths, codes, result kinds and the result word for the move-to-front
// zero-run decoder and its list cells.
// ----------------------------------------------------------------------------
package mtfzr_pkg;

   // list geometry
   localparam int LIST_SIZE  = 256;
   localparam int BYTE_W     = 8;
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (LIST_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;

   // field widths
   localparam int CODE_W    = 9;
   localparam int KIND_W    = 3;
   localparam int COUNT_W   = 20;
   localparam int RUN_W     = 31;
   localparam int RUN_CNT_W = 5;

   localparam int MAX_RUN_SYMBOLS = 30;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(900000);

   // input codes
   localparam logic [CODE_W-1:0] CODE_RUN_A = CODE_W'(257);
   localparam logic [CODE_W-1:0] CODE_RUN_B = CODE_W'(258);
   localparam logic [CODE_W-1:0] CODE_EOB   = CODE_W'(259);
   localparam logic [CODE_W-1:0] CODE_LAST_LITERAL = CODE_W'(255);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BYTES    = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_EOB      = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_RUN_LONG = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_ILLEGAL  = KIND_W'(4);

   typedef logic [BYTE_W-1:0] byte_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_GATHER = 4'b0010,
      S_EVAL   = 4'b0100,
      S_SECOND = 4'b1000
   } state_type;

   // control broadcast to every list cell
   typedef struct packed {
      logic     shift;
      logic     clear;
      byte_type pos;
   } cell_ctrl_type;

   // one result word
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      byte_type           byte_value;
      logic [COUNT_W-1:0] repeat_count;
      logic [COUNT_W-1:0] block_bytes;
      logic               last_of_item;
   } rsp_word_type;

   function automatic rsp_word_type make_word(
      input logic [KIND_W-1:0]  kind,
      input byte_type           byte_value,
      input logic [COUNT_W-1:0] repeat_count,
      input logic [COUNT_W-1:0] block_bytes,
      input logic               last_of_item
   );
      rsp_word_type w;
      w.kind         = kind;
      w.byte_value   = byte_value;
      w.repeat_count = repeat_count;
      w.block_bytes  = block_bytes;
      w.last_of_item = last_of_item;
      return w;
   endfunction

endpackage

// ===== rtl/mtfzr_cell.sv =====
// ----------------------------------------------------------------------------
// mtfzr_cell: one entry of the move-to-front list
// Holds one byte; on a shift, cells at or below the selected position take
// their left neighbour's byte. Puts its byte on hit_out when it is the selected one.
// ----------------------------------------------------------------------------
module mtfzr_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mtfzr_pkg::cell_ctrl_type ctrl,
   input  mtfzr_pkg::byte_type    cell_index,
   input  mtfzr_pkg::byte_type    left_in,
   output mtfzr_pkg::byte_type    byte_out,
   output mtfzr_pkg::byte_type    hit_out
);
   import mtfzr_pkg::*;

   byte_type value_ff;
   byte_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.clear) begin
         value_in = cell_index;
      end else if (ctrl.shift && (cell_index <= ctrl.pos)) begin
         value_in = left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= cell_index;
      end else begin
         value_ff <= value_in;
      end
   end

   assign byte_out = value_ff;
   assign hit_out  = (cell_index == ctrl.pos) ? value_ff : '0;

endmodule

// ===== rtl/mtfzr_gather.sv =====
// ----------------------------------------------------------------------------
// mtfzr_gather: selected-entry collection
// ORs the masked cell outputs in registered groups, then merges the groups.
// ----------------------------------------------------------------------------
module mtfzr_gather (
   input  logic                clock,
   input  mtfzr_pkg::byte_type hits [mtfzr_pkg::LIST_SIZE],
   output mtfzr_pkg::byte_type fetched
);
   import mtfzr_pkg::*;

   byte_type group_ff [NUM_GROUPS];
   byte_type group_in [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int m = 0; m < GROUP_SIZE; m++) begin
            if (g * GROUP_SIZE + m < LIST_SIZE) begin
               group_in[g] = group_in[g] | hits[g * GROUP_SIZE + m];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      fetched = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         fetched = fetched | group_ff[g];
      end
   end

endmodule

// ===== rtl/move_to_front_zero_run_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// move_to_front_zero_run_decoder_unit: move-to-front decoder with zero runs
// Turns move-to-front codes into byte/repeat words, keeping the list in a
// row of cells and the run value and block byte count in the sequencer.
// ----------------------------------------------------------------------------
// Usage
//  req_*  : one code per word (1..255 list position, 257 run A, 258 run B,
//           259 end of block, anything else illegal).
//  rsp_*  : result words; a code yields none, one or two of them, the last
//           one flagged by rsp_last_of_item. A run closing within the limit
//           gives the run word first, then the word of the closing code.
//  csr_*  : block limit write, always ready; write only while idle.
// Timing
//  A code is taken in S_IDLE, the selected list entry is collected from
//  the cell row through a registered OR tree in S_GATHER, and the code is
//  applied in S_EVAL; S_SECOND follows when a second word is due. The
//  OR-tree register is what S_GATHER waits on. A new code is taken only
//  once the sequencer is back in S_IDLE.
// Reset
//  The list returns to the identity, run and byte count clear, limit is
//  900000. End of block and every error word clear the block state too.
// Stall
//  The result sits in an output register; the next code is accepted while
//  it waits, but is applied only once the register can take its word.
// ----------------------------------------------------------------------------
module move_to_front_zero_run_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mtfzr_pkg::CODE_W-1:0]          req_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mtfzr_pkg::KIND_W-1:0]          rsp_kind,
   output logic [mtfzr_pkg::BYTE_W-1:0]          rsp_byte_value,
   output logic [mtfzr_pkg::COUNT_W-1:0]         rsp_repeat_count,
   output logic [mtfzr_pkg::COUNT_W-1:0]         rsp_block_bytes,
   output logic                                  rsp_last_of_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mtfzr_pkg::COUNT_W-1:0]         csr_block_limit
);
   import mtfzr_pkg::*;

   // sequencer and block state
   state_type             state_ff, state_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [RUN_W-1:0]      run_value_ff, run_value_in;
   logic [RUN_CNT_W-1:0]  run_symbols_ff, run_symbols_in;
   logic [COUNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [COUNT_W-1:0]    block_limit_ff;

   // output register and the held second word
   rsp_word_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          hold_ff, hold_in;

   // cell row
   cell_ctrl_type         cell_ctrl;
   byte_type              cell_index [LIST_SIZE];
   byte_type              cell_byte  [LIST_SIZE];
   byte_type              cell_hit   [LIST_SIZE];
   byte_type              fetched;

   // decode of the code being applied
   logic                  is_run, is_lit, is_eob, have_run;
   logic [RUN_W:0]        total;
   logic                  run_ovf, total_at_limit, count_at_limit, at_limit;
   logic [COUNT_W-1:0]    cnt_base;
   rsp_word_type          close_word;
   logic                  slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // --- list cells: cell 0 takes the fetched byte, the rest their neighbour
   for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
      assign cell_index[i] = BYTE_W'(i);
      if (i == 0) begin : g_head
         mtfzr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .cell_index (cell_index[i]),
            .left_in    (fetched),
            .byte_out   (cell_byte[i]),
            .hit_out    (cell_hit[i])
         );
      end else begin : g_body
         mtfzr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .cell_index (cell_index[i]),
            .left_in    (cell_byte[i-1]),
            .byte_out   (cell_byte[i]),
            .hit_out    (cell_hit[i])
         );
      end
   end

   mtfzr_gather u_gather (
      .clock   (clock),
      .hits    (cell_hit),
      .fetched (fetched)
   );

   // --- decode
   assign is_run   = (code_ff == CODE_RUN_A) || (code_ff == CODE_RUN_B);
   assign is_eob   = (code_ff == CODE_EOB);
   assign is_lit   = (code_ff != '0) && (code_ff < CODE_W'(LIST_SIZE))
                     && (code_ff <= CODE_LAST_LITERAL);
   assign have_run = (run_symbols_ff != '0);

   // run total and both limit checks side by side
   assign total          = (RUN_W+1)'(byte_count_ff) + (RUN_W+1)'(run_value_ff);
   assign run_ovf        = total > (RUN_W+1)'(block_limit_ff);
   assign total_at_limit = total >= (RUN_W+1)'(block_limit_ff);
   assign count_at_limit = byte_count_ff >= block_limit_ff;
   assign cnt_base       = have_run ? total[COUNT_W-1:0] : byte_count_ff;
   assign at_limit       = have_run ? total_at_limit : count_at_limit;

   // --- sequencer
   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      run_value_in   = run_value_ff;
      run_symbols_in = run_symbols_ff;
      byte_count_in  = byte_count_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      hold_in        = hold_ff;
      close_word     = hold_ff;
      cell_ctrl.shift = 1'b0;
      cell_ctrl.clear = 1'b0;
      cell_ctrl.pos   = code_ff[BYTE_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code_in  = req_code;
               state_in = S_GATHER;
            end
         end
         S_GATHER: begin
            // selected entry settles in the gather registers
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (slot_free) begin
               state_in = S_IDLE;
               if (is_run) begin
                  if (run_symbols_ff >= RUN_CNT_W'(MAX_RUN_SYMBOLS)) begin
                     rsp_in          = make_word(KIND_RUN_LONG, '0, '0, byte_count_ff, 1'b1);
                     rsp_valid_in    = 1'b1;
                     run_value_in    = '0;
                     run_symbols_in  = '0;
                     byte_count_in   = '0;
                     cell_ctrl.clear = 1'b1;
                  end else begin
                     // A adds two, B adds one, most significant symbol first
                     run_value_in   = {run_value_ff[RUN_W-2:0], 1'b0}
                                      + ((code_ff == CODE_RUN_A) ? RUN_W'(2) : RUN_W'(1));
                     run_symbols_in = run_symbols_ff + RUN_CNT_W'(1);
                  end
               end else if (have_run && run_ovf) begin
                  // run does not fit: closing code is dropped
                  rsp_in          = make_word(KIND_OVERFLOW, '0, '0, byte_count_ff, 1'b1);
                  rsp_valid_in    = 1'b1;
                  run_value_in    = '0;
                  run_symbols_in  = '0;
                  byte_count_in   = '0;
                  cell_ctrl.clear = 1'b1;
               end else begin
                  run_value_in   = '0;
                  run_symbols_in = '0;
                  byte_count_in  = cnt_base;
                  if (is_lit && !at_limit) begin
                     close_word      = make_word(KIND_BYTES, fetched, COUNT_W'(1),
                                                 cnt_base + COUNT_W'(1), 1'b1);
                     byte_count_in   = cnt_base + COUNT_W'(1);
                     cell_ctrl.shift = 1'b1;
                  end else begin
                     if (is_eob) begin
                        close_word = make_word(KIND_EOB, '0, '0, cnt_base, 1'b1);
                     end else if (is_lit) begin
                        close_word = make_word(KIND_OVERFLOW, '0, '0, cnt_base, 1'b1);
                     end else begin
                        close_word = make_word(KIND_ILLEGAL, '0, '0, cnt_base, 1'b1);
                     end
                     byte_count_in   = '0;
                     cell_ctrl.clear = 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  if (have_run) begin
                     // run word uses the list front before this code moves it
                     rsp_in   = make_word(KIND_BYTES, cell_byte[0],
                                          run_value_ff[COUNT_W-1:0], cnt_base, 1'b0);
                     hold_in  = close_word;
                     state_in = S_SECOND;
                  end else begin
                     rsp_in = close_word;
                  end
               end
            end
         end
         S_SECOND: begin
            if (slot_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_value_ff   <= '0;
         run_symbols_ff <= '0;
         byte_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         block_limit_ff <= LIMIT_RESET;
      end else begin
         state_ff       <= state_in;
         run_value_ff   <= run_value_in;
         run_symbols_ff <= run_symbols_in;
         byte_count_ff  <= byte_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid) begin
            block_limit_ff <= csr_block_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_byte_value   = rsp_ff.byte_value;
   assign rsp_repeat_count = rsp_ff.repeat_count;
   assign rsp_block_bytes  = rsp_ff.block_bytes;
   assign rsp_last_of_item = rsp_ff.last_of_item;

   // --- checks
   // a run word that is not the last one always has its partner waiting
   a_second_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_of_item) |-> (state_ff == S_SECOND))
      else $error("non-final word without a pending second word");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_symbols_ff <= RUN_CNT_W'(MAX_RUN_SYMBOLS))
      else $error("run symbol count beyond its limit");

   a_bytes_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == KIND_BYTES)) |-> (rsp_ff.repeat_count != '0))
      else $error("byte word with zero repeat count");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind != KIND_BYTES))
      |-> (rsp_ff.byte_value == '0 && rsp_ff.repeat_count == '0 && rsp_ff.last_of_item))
      else $error("status word carries byte data or is not final");

   a_clear_after_status: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && (rsp_ff.kind != KIND_BYTES)) |-> (byte_count_ff == '0))
      else $error("block state not cleared after a status word");

endmodule
